>>> rtl/vsb_pkg.sv
// Shared constants for the vehicle state battery smoother.
`timescale 1ns / 1ps
`default_nettype none

package vsb_pkg;

    // Depth of the battery history.
    localparam int HIST_DEPTH = 8;

    // Widths that follow from the history depth.
    localparam int PTR_W  = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int CNT_W  = $clog2(HIST_DEPTH + 1);
    localparam int BATT_W = 8;
    localparam int SUM_W  = BATT_W + $clog2(HIST_DEPTH);
    localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

    // Field widths.
    localparam int GEAR_W  = 3;
    localparam int SPEED_W = 16;
    localparam int DB_W    = 8;

    // Stream packing.
    localparam int TDATA_W  = 32;
    localparam int S_USER_W = 1;
    localparam int M_USER_W = 3;

    // Reset values and codes.
    localparam logic [DB_W-1:0]   DEADBAND_RESET = DB_W'(2);
    localparam logic [GEAR_W-1:0] GEAR_P         = GEAR_W'(0);
    localparam logic              ACT_STATE      = 1'b0;
    localparam logic              ACT_GEAR       = 1'b1;

endpackage

`default_nettype wire

>>> rtl/vsb_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module vsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/vehicle_state_battery_smoother.sv
// Top level of the vehicle state holder with a smoothed battery level.
//
// Requests enter on the s_ stream: s_tuser carries the action (0 = full vehicle
// state, 1 = gear change only), s_tdata carries gear, speed and raw battery. One
// result leaves on the m_ stream for every request: the current gear, speed and
// displayed battery level, with three changed flags in m_tuser. The user writes
// the deadband register through cfg_we / cfg_wdata only while idle (not enforced).
//
// A request that does not touch the battery history goes from acceptance
// straight to ST_DONE, which loads its result. A request whose raw battery
// differs from the shown level reads one history entry on acceptance and
// rewrites it in ST_READ, then runs a restoring divider of the running sum
// by the fill count, one quotient bit a cycle over the SUM_W = 11 bits, then
// checks the deadband in ST_EVAL and loads the result in ST_DONE. The next
// request is accepted once the previous one has moved into the output
// register, even if the receiver has not taken that result yet.
//
// Reset clears gear (to P), speed, shown level, fill count, pointer and the
// running sum, and sets the deadband to 2. History entries are only ever used
// once written, so the memory needs no clearing pass. While m_tready is low a
// finished result waits in the output register and the next stalls in ST_DONE.
`timescale 1ns / 1ps
`default_nettype none

module vehicle_state_battery_smoother (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Request stream.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // s_tdata, from bit 0: gear_code[2:0], speed_in[18:3], battery_raw[26:19], zeros
    input  wire logic [vsb_pkg::TDATA_W-1:0]   s_tdata,
    // s_tuser: action[0]
    input  wire logic [vsb_pkg::S_USER_W-1:0]  s_tuser,
    // Result stream.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // m_tdata, from bit 0: gear_out[2:0], speed_out[18:3], battery_level[26:19], zeros
    output logic      [vsb_pkg::TDATA_W-1:0]   m_tdata,
    // m_tuser, from bit 0: gear_changed, speed_changed, battery_changed
    output logic      [vsb_pkg::M_USER_W-1:0]  m_tuser,
    // Deadband register write.
    input  wire logic                          cfg_we,
    input  wire logic [vsb_pkg::DB_W-1:0]      cfg_wdata
);

    localparam int GW  = vsb_pkg::GEAR_W;
    localparam int SW  = vsb_pkg::SPEED_W;
    localparam int BW  = vsb_pkg::BATT_W;
    localparam int PW  = vsb_pkg::PTR_W;
    localparam int CW  = vsb_pkg::CNT_W;
    localparam int UW  = vsb_pkg::SUM_W;
    localparam int TW  = vsb_pkg::STEP_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_EVAL,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [GW-1:0]       gear_reg, gear_next;
    logic [SW-1:0]       speed_reg, speed_next;
    logic [BW-1:0]       shown_reg, shown_next;
    logic [vsb_pkg::DB_W-1:0] deadband_reg, deadband_next;
    logic [PW-1:0]       wp_reg, wp_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic [UW-1:0]       sum_reg, sum_next;
    logic [BW-1:0]       raw_reg, raw_next;
    logic [UW-1:0]       quo_reg, quo_next;
    logic [CW-1:0]       rem_reg, rem_next;
    logic [TW-1:0]       step_reg, step_next;
    logic                g_chg_reg, g_chg_next;
    logic                s_chg_reg, s_chg_next;
    logic                b_chg_reg, b_chg_next;
    logic                m_valid_reg, m_valid_next;
    logic [vsb_pkg::TDATA_W-1:0]  m_data_reg, m_data_next;
    logic [vsb_pkg::M_USER_W-1:0] m_user_reg, m_user_next;

    // Request fields.
    logic          in_action;
    logic [GW-1:0] in_gear;
    logic [SW-1:0] in_speed;
    logic [BW-1:0] in_raw;
    logic          s_accept;

    // History memory port.
    logic          ram_wr_en;
    logic          ram_rd_en;
    logic [BW-1:0] ram_rd_data;

    // Datapath helpers.
    logic          hist_full;
    logic [BW-1:0] old_entry;
    logic [UW-1:0] sum_upd;
    logic [CW:0]   trial;
    logic [CW:0]   trial_sub;
    logic [BW-1:0] avg;
    logic [BW-1:0] diff;

    assign in_action = s_tuser[0];
    assign in_gear   = s_tdata[GW-1:0];
    assign in_speed  = s_tdata[GW+SW-1:GW];
    assign in_raw    = s_tdata[GW+SW+BW-1:GW+SW];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // The entry at the write pointer is read on acceptance and rewritten in the
    // next cycle (ST_READ), so the read and the write never meet on the same cycle.
    assign ram_rd_en = s_accept;

    vsb_ram #(
        .WIDTH (BW),
        .DEPTH (vsb_pkg::HIST_DEPTH)
    ) u_hist (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wp_reg),
        .wr_data (raw_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (wp_reg),
        .rd_data (ram_rd_data)
    );

    // Once the history is full every entry is part of the running sum, so the
    // entry being replaced has to come out of it first.
    assign hist_full = (fill_reg == CW'(vsb_pkg::HIST_DEPTH));
    assign old_entry = hist_full ? ram_rd_data : '0;
    assign sum_upd   = sum_reg - UW'(old_entry) + UW'(raw_reg);

    // One restoring division step: bring down the next dividend bit.
    assign trial     = {rem_reg, quo_reg[UW-1]};
    assign trial_sub = trial - {1'b0, fill_reg};

    // The average of 8-bit values always fits in 8 bits.
    assign avg  = quo_reg[BW-1:0];
    assign diff = (avg >= shown_reg) ? (avg - shown_reg) : (shown_reg - avg);

    always_comb
    begin
        state_next    = state_reg;
        gear_next     = gear_reg;
        speed_next    = speed_reg;
        shown_next    = shown_reg;
        deadband_next = deadband_reg;
        wp_next       = wp_reg;
        fill_next     = fill_reg;
        sum_next      = sum_reg;
        raw_next      = raw_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        step_next     = step_reg;
        g_chg_next    = g_chg_reg;
        s_chg_next    = s_chg_reg;
        b_chg_next    = b_chg_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        ram_wr_en     = 1'b0;

        if (cfg_we)
        begin
            deadband_next = cfg_wdata;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    g_chg_next = (gear_reg != in_gear);
                    gear_next  = in_gear;
                    s_chg_next = 1'b0;
                    b_chg_next = 1'b0;
                    raw_next   = in_raw;
                    state_next = ST_DONE;
                    if (in_action == vsb_pkg::ACT_STATE)
                    begin
                        s_chg_next = (speed_reg != in_speed);
                        speed_next = in_speed;
                        if (shown_reg != in_raw)
                        begin
                            b_chg_next = 1'b1;
                            state_next = ST_READ;
                        end
                    end
                end
            end

            ST_READ:
            begin
                // Replace the entry at the pointer and update the sum.
                ram_wr_en = 1'b1;
                sum_next  = sum_upd;
                quo_next  = sum_upd;
                rem_next  = '0;
                step_next = '0;
                if (wp_reg == PW'(vsb_pkg::HIST_DEPTH - 1))
                begin
                    wp_next = '0;
                end
                else
                begin
                    wp_next = wp_reg + PW'(1);
                end
                if (!hist_full)
                begin
                    fill_next = fill_reg + CW'(1);
                end
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                if (!trial_sub[CW])
                begin
                    rem_next = trial_sub[CW-1:0];
                    quo_next = {quo_reg[UW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[CW-1:0];
                    quo_next = {quo_reg[UW-2:0], 1'b0};
                end
                step_next = step_reg + TW'(1);
                if (step_reg == TW'(UW - 1))
                begin
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                // The deadband only applies once the history is full.
                if (!(hist_full && (diff < deadband_reg)))
                begin
                    shown_next = avg;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = vsb_pkg::TDATA_W'({shown_reg, speed_reg, gear_reg});
                    m_user_next  = {b_chg_reg, s_chg_reg, g_chg_reg};
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            gear_reg     <= vsb_pkg::GEAR_P;
            speed_reg    <= '0;
            shown_reg    <= '0;
            deadband_reg <= vsb_pkg::DEADBAND_RESET;
            wp_reg       <= '0;
            fill_reg     <= '0;
            sum_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            gear_reg     <= gear_next;
            speed_reg    <= speed_next;
            shown_reg    <= shown_next;
            deadband_reg <= deadband_next;
            wp_reg       <= wp_next;
            fill_reg     <= fill_next;
            sum_reg      <= sum_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        raw_reg    <= raw_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        step_reg   <= step_next;
        g_chg_reg  <= g_chg_next;
        s_chg_reg  <= s_chg_next;
        b_chg_reg  <= b_chg_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

endmodule

`default_nettype wire
